// ===== rtl/stable_priority_batch_sorter_top_defines.svh =====
// Assertion macros shared by the batch sorter RTL.
// No dependencies; modules that assert include this file by name.
`ifndef STABLE_PRIORITY_BATCH_SORTER_TOP_DEFINES_SVH
`define STABLE_PRIORITY_BATCH_SORTER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define SPBS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define SPBS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/spbs_pkg.sv =====
// Shared constants, codes and types of the batch sorter.
// No dependencies; imported by every RTL module of the block except spbs_ram.
package spbs_pkg;

   localparam int SPBS_MAX_ENTRIES = 32;
   localparam int SPBS_ID_BITS     = 16;
   localparam int SPBS_FIFO_DEPTH  = 2;

   localparam int ENTRY_ID_W = 16;
   localparam int LEVEL_W    = 2;
   localparam int BATCH_W    = 6;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [BATCH_W-1:0] BATCH_RESET = 6'd32;

   // register index, taken from paddr[2]
   localparam logic REG_BATCH_SIZE = 1'b0;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_LIST   = 1'b1;

   localparam logic [LEVEL_W-1:0] LVL_HIGH    = 2'd0;
   localparam logic [LEVEL_W-1:0] LVL_INVALID = 2'd3;

   typedef enum logic [1:0] {
      ST_ACCEPTED  = 2'd0,
      ST_DUPLICATE = 2'd1,
      ST_INVALID   = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      status_type         status;
      logic [LEVEL_W-1:0] level;
      logic               flush;
   } cmd_ctrl_type;

   localparam int CTRL_W = $bits(cmd_ctrl_type);

endpackage

// ===== rtl/spbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/spbs_fifo.sv =====
// Short command queue between the front and back of the batch sorter.
// Depends on spbs_pkg for the default depth; DEPTH is a power of two.
module spbs_fifo import spbs_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = SPBS_FIFO_DEPTH,
   localparam int AW = $clog2(DEPTH),
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/spbs_front.sv =====
// Front end: accepts requests, checks duplicates in parallel, classifies,
// stores accepted entries and queues commands. Depends on spbs_pkg.
`include "stable_priority_batch_sorter_top_defines.svh"
module spbs_front import spbs_pkg::*; #(
   parameter int MAX_ENTRIES = SPBS_MAX_ENTRIES,
   parameter int ID_BITS = SPBS_ID_BITS,
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1),
   localparam int AW = $clog2(MAX_ENTRIES)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [BATCH_W-1:0]    batch_size,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [ENTRY_ID_W-1:0] req_entry_id,
   input  logic [LEVEL_W-1:0]    req_level_code,
   input  logic                  q_full,
   output logic                  q_push,
   output cmd_ctrl_type          cmd_ctrl,
   output logic [ID_BITS-1:0]    cmd_id,
   output logic [CNT_W-1:0]      cmd_total,
   output logic                  ram_we,
   output logic [AW-1:0]         ram_waddr,
   output logic [ID_BITS+1:0]    ram_wdata,
   input  logic                  flush_done
);

   localparam logic [BATCH_W-1:0] MAX_B = BATCH_W'(MAX_ENTRIES);

   logic [ID_BITS-1:0]     ids_ff [MAX_ENTRIES];
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   busy_ff, busy_in;
   logic [ID_BITS-1:0]     id_w;
   logic [BATCH_W-1:0]     lim_b;
   logic [CNT_W-1:0]       limit;
   logic [CNT_W-1:0]       count_inc;
   logic [MAX_ENTRIES-1:0] hit;
   logic                   is_full;
   logic                   store;
   logic                   accept;

   for (genvar b = 0; b < ID_BITS; b++) begin : g_id
      if (b < ENTRY_ID_W) begin : g_bit
         assign id_w[b] = req_entry_id[b];
      end else begin : g_zero
         assign id_w[b] = 1'b0;
      end
   end

   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cmp
      assign hit[g] = (CNT_W'(g) < count_ff) && (ids_ff[g] == id_w);
   end

   assign lim_b = (batch_size == '0) ? BATCH_W'(1) :
                  (batch_size > MAX_B) ? MAX_B : batch_size;
   assign limit     = lim_b[CNT_W-1:0];
   assign is_full   = (count_ff >= limit);
   assign count_inc = count_ff + CNT_W'(1);

   assign req_ready = !busy_ff && !q_full;
   assign accept    = req_valid && req_ready;
   assign q_push    = accept;
   assign cmd_id    = id_w;

   always_comb begin
      cmd_ctrl.status = ST_ACCEPTED;
      cmd_ctrl.level  = req_level_code;
      cmd_ctrl.flush  = 1'b0;
      cmd_total       = count_ff;
      store           = 1'b0;
      if (is_full) begin
         cmd_ctrl.status = ST_FULL;
         cmd_ctrl.flush  = 1'b1;
      end else if (|hit) begin
         cmd_ctrl.status = ST_DUPLICATE;
      end else if (req_level_code == LVL_INVALID) begin
         cmd_ctrl.status = ST_INVALID;
      end else begin
         store = 1'b1;
         if (count_inc >= limit) begin
            cmd_ctrl.flush = 1'b1;
            cmd_total      = count_inc;
         end
      end
   end

   assign ram_we    = accept && store;
   assign ram_waddr = count_ff[AW-1:0];
   assign ram_wdata = {req_level_code, id_w};

   always_comb begin
      count_in = count_ff;
      busy_in  = busy_ff;
      if (accept && cmd_ctrl.flush) begin
         count_in = '0;
         busy_in  = 1'b1;
      end else if (ram_we) begin
         count_in = count_inc;
      end
      if (flush_done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_we) begin
         ids_ff[count_ff[AW-1:0]] <= id_w;
      end
   end

   `SPBS_ASSERT_NOW(a_count_range, 1'b1, count_ff <= CNT_W'(MAX_ENTRIES), "count overflow")
   `SPBS_ASSERT_NEXT(a_flush_blocks, accept && cmd_ctrl.flush, busy_ff && count_ff == '0, "flush not held")
   `SPBS_ASSERT_NOW(a_busy_stall, busy_ff, !req_ready && count_ff == '0, "request taken during flush")

endmodule

// ===== rtl/spbs_back.sv =====
// Back end: pops commands, emits status results and walks the store by
// level to emit the ordered batch. Depends on spbs_pkg.
`include "stable_priority_batch_sorter_top_defines.svh"
module spbs_back import spbs_pkg::*; #(
   parameter int MAX_ENTRIES = SPBS_MAX_ENTRIES,
   parameter int ID_BITS = SPBS_ID_BITS,
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1),
   localparam int AW = $clog2(MAX_ENTRIES)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   output logic                  q_pop,
   input  cmd_ctrl_type          cmd_ctrl,
   input  logic [ID_BITS-1:0]    cmd_id,
   input  logic [CNT_W-1:0]      cmd_total,
   output logic                  ram_re,
   output logic [AW-1:0]         ram_raddr,
   input  logic [ID_BITS+1:0]    ram_rdata,
   output logic                  flush_done,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_result_kind,
   output logic [1:0]            rsp_status_code,
   output logic [ENTRY_ID_W-1:0] rsp_out_id,
   output logic [LEVEL_W-1:0]    rsp_out_level,
   output logic                  rsp_last
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_READ  = 3'b010,
      S_CHECK = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [LEVEL_W-1:0]    lvl_ff, lvl_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [CNT_W-1:0]      emitted_ff, emitted_in;
   logic [CNT_W-1:0]      total_ff, total_in;

   logic                  valid_ff, valid_in;
   logic                  kind_ff, kind_in;
   status_type            status_ff, status_in;
   logic [ENTRY_ID_W-1:0] id_ff, id_in;
   logic [LEVEL_W-1:0]    level_ff, level_in;
   logic                  last_ff, last_in;

   logic                  out_free;
   logic                  load;
   logic [ID_BITS-1:0]    id_sel;
   logic [ENTRY_ID_W-1:0] id_ext;
   logic [LEVEL_W-1:0]    rd_level;
   logic                  end_pass;

   assign rd_level = ram_rdata[ID_BITS +: LEVEL_W];
   assign id_sel   = (state_ff == S_IDLE) ? cmd_id : ram_rdata[ID_BITS-1:0];

   for (genvar b = 0; b < ENTRY_ID_W; b++) begin : g_out
      if (b < ID_BITS) begin : g_bit
         assign id_ext[b] = id_sel[b];
      end else begin : g_zero
         assign id_ext[b] = 1'b0;
      end
   end

   assign out_free  = !valid_ff || rsp_ready;
   assign ram_re    = (state_ff == S_READ);
   assign ram_raddr = idx_ff;
   assign end_pass  = (CNT_W'(idx_ff) + CNT_W'(1) == total_ff);

   always_comb begin
      state_in   = state_ff;
      lvl_in     = lvl_ff;
      idx_in     = idx_ff;
      emitted_in = emitted_ff;
      total_in   = total_ff;
      q_pop      = 1'b0;
      flush_done = 1'b0;
      load       = 1'b0;
      kind_in    = KIND_STATUS;
      status_in  = ST_ACCEPTED;
      id_in      = id_ext;
      level_in   = lvl_ff;
      last_in    = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (!q_empty && out_free) begin
               q_pop     = 1'b1;
               load      = 1'b1;
               status_in = cmd_ctrl.status;
               level_in  = cmd_ctrl.level;
               last_in   = !(cmd_ctrl.flush && cmd_total != '0);
               if (cmd_ctrl.flush && cmd_total != '0) begin
                  state_in   = S_READ;
                  lvl_in     = LVL_HIGH;
                  idx_in     = '0;
                  emitted_in = '0;
                  total_in   = cmd_total;
               end
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (rd_level != lvl_ff || out_free) begin
               if (rd_level == lvl_ff) begin
                  load       = 1'b1;
                  kind_in    = KIND_LIST;
                  last_in    = (emitted_ff + CNT_W'(1) == total_ff);
                  emitted_in = emitted_ff + CNT_W'(1);
               end
               if (load && last_in) begin
                  flush_done = 1'b1;
                  state_in   = S_IDLE;
               end else begin
                  state_in = S_READ;
                  if (end_pass) begin
                     idx_in = '0;
                     lvl_in = lvl_ff + LEVEL_W'(1);
                  end else begin
                     idx_in = idx_ff + AW'(1);
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      valid_in = load ? 1'b1 : (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff     <= lvl_in;
      idx_ff     <= idx_in;
      emitted_ff <= emitted_in;
      total_ff   <= total_in;
      if (load) begin
         kind_ff   <= kind_in;
         status_ff <= status_in;
         id_ff     <= id_in;
         level_ff  <= level_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_status_code = status_ff;
   assign rsp_out_id      = id_ff;
   assign rsp_out_level   = level_ff;
   assign rsp_last        = last_ff;

   `SPBS_ASSERT_NOW(a_scan_count, state_ff != S_IDLE, emitted_ff < total_ff, "scan past batch end")
   `SPBS_ASSERT_NOW(a_scan_level, state_ff != S_IDLE, lvl_ff != LVL_INVALID, "scan level overrun")
   `SPBS_ASSERT_NEXT(a_done_last, flush_done, valid_ff && last_ff && kind_ff == KIND_LIST, "flush end without last")

endmodule

// ===== rtl/stable_priority_batch_sorter_top.sv =====
// Stable priority batch sorter: top level with the batch size register.
// Depends on spbs_pkg, spbs_front, spbs_fifo, spbs_ram and spbs_back.
//
// Usage:
//   req channel (valid/ready) offers an entry id and a level code. Every
//   request yields one status result on the rsp channel (valid/ready). When
//   a request completes a batch, or finds the batch already full, the status
//   result is followed by all held entries, level 0 first, arrival order
//   within a level; rsp_last marks the final result of the request.
//   csr port: batch_size at byte address 0, written while the block is idle.
//   A status result is held in the command queue, then in the output register.
//   Throughput: 1 request per cycle while no batch completes and rsp_ready
//   stays high. A completing request walks the store once per level pass,
//   reading each held entry through the single RAM read port (S_READ, then
//   S_CHECK), and req_ready stays low until the last list result
//   is loaded.
//   Reset empties the store and sets batch_size to 32; no clearing pass.
//   A stalled rsp side holds the output register; the 2-entry queue then
//   fills and req_ready drops.
module stable_priority_batch_sorter_top import spbs_pkg::*; #(
   parameter int MAX_ENTRIES = SPBS_MAX_ENTRIES,
   parameter int ID_BITS = SPBS_ID_BITS,
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1),
   localparam int AW = $clog2(MAX_ENTRIES),
   localparam int QW = CTRL_W + ID_BITS + CNT_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [ENTRY_ID_W-1:0] req_entry_id,
   input  logic [LEVEL_W-1:0]    req_level_code,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_result_kind,
   output logic [1:0]            rsp_status_code,
   output logic [ENTRY_ID_W-1:0] rsp_out_id,
   output logic [LEVEL_W-1:0]    rsp_out_level,
   output logic                  rsp_last,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [BATCH_W-1:0] batch_ff, batch_in;
   logic               csr_hit;

   cmd_ctrl_type       f_ctrl, b_ctrl;
   logic [ID_BITS-1:0] f_id, b_id;
   logic [CNT_W-1:0]   f_total, b_total;
   logic [QW-1:0]      q_wdata, q_rdata;
   logic               q_push, q_pop, q_full, q_empty;

   logic               ram_we, ram_re;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [ID_BITS+1:0] ram_wdata, ram_rdata;
   logic               flush_done;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == REG_BATCH_SIZE);
   assign csr_prdata = csr_hit ? CSR_DATA_W'(batch_ff) : '0;
   assign batch_in   = (csr_psel && csr_penable && csr_pwrite && csr_hit) ?
                       csr_pwdata[BATCH_W-1:0] : batch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_ff <= BATCH_RESET;
      end else begin
         batch_ff <= batch_in;
      end
   end

   spbs_front #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .ID_BITS(ID_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .batch_size(batch_ff),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_entry_id(req_entry_id),
      .req_level_code(req_level_code),
      .q_full(q_full),
      .q_push(q_push),
      .cmd_ctrl(f_ctrl),
      .cmd_id(f_id),
      .cmd_total(f_total),
      .ram_we(ram_we),
      .ram_waddr(ram_waddr),
      .ram_wdata(ram_wdata),
      .flush_done(flush_done)
   );

   assign q_wdata = {f_ctrl, f_id, f_total};
   assign b_ctrl  = q_rdata[QW-1 -: CTRL_W];
   assign b_id    = q_rdata[CNT_W +: ID_BITS];
   assign b_total = q_rdata[CNT_W-1:0];

   spbs_fifo #(
      .WIDTH(QW),
      .DEPTH(SPBS_FIFO_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .wr_data(q_wdata),
      .full(q_full),
      .pop(q_pop),
      .rd_data(q_rdata),
      .empty(q_empty)
   );

   spbs_ram #(
      .WIDTH(ID_BITS + LEVEL_W),
      .DEPTH(MAX_ENTRIES)
   ) u_store (
      .clock(clock),
      .wr_en(ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en(ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   spbs_back #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .ID_BITS(ID_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_empty(q_empty),
      .q_pop(q_pop),
      .cmd_ctrl(b_ctrl),
      .cmd_id(b_id),
      .cmd_total(b_total),
      .ram_re(ram_re),
      .ram_raddr(ram_raddr),
      .ram_rdata(ram_rdata),
      .flush_done(flush_done),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_result_kind(rsp_result_kind),
      .rsp_status_code(rsp_status_code),
      .rsp_out_id(rsp_out_id),
      .rsp_out_level(rsp_out_level),
      .rsp_last(rsp_last)
   );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for stable_priority_batch_sorter_top: request driver, result monitor,
// in-bench sorter prediction and APB batch_size writes. Needs spbs_pkg and the block's RTL.
module tb;
   import spbs_pkg::*;

   localparam logic [LEVEL_W-1:0] LVL_MID = 2'd1;
   localparam logic [LEVEL_W-1:0] LVL_LOW = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] BATCH_SIZE_ADDR = {REG_BATCH_SIZE, 2'b00};
   localparam int PRESSURE_AT = 120;
   localparam int PRESSURE_CYCLES = 100;

   typedef struct {
      logic [ENTRY_ID_W-1:0] id;
      logic [LEVEL_W-1:0]    lvl;
   } entry_req_type;

   typedef struct {
      logic                  kind;
      status_type            status;
      logic [ENTRY_ID_W-1:0] id;
      logic [LEVEL_W-1:0]    lvl;
      logic                  last;
   } sort_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [ENTRY_ID_W-1:0] req_entry_id = '0;
   logic [LEVEL_W-1:0]    req_level_code = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_result_kind;
   logic [1:0]            rsp_status_code;
   logic [ENTRY_ID_W-1:0] rsp_out_id;
   logic [LEVEL_W-1:0]    rsp_out_level;
   logic                  rsp_last;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   entry_req_type         req_backlog[$];
   sort_rsp_type          due_results[$];
   sort_rsp_type          want;

   // predicted block state
   logic [ENTRY_ID_W-1:0] batch_ids[SPBS_MAX_ENTRIES];
   logic [LEVEL_W-1:0]    batch_lvls[SPBS_MAX_ENTRIES];
   int                    batch_fill = 0;
   logic [BATCH_W-1:0]    batch_reg = BATCH_RESET;

   int idle_pct = 0;
   int req_gap = 0;
   int rsp_stall = 0;
   int hold_left = 0;
   bit pressure_done = 0;
   int accepted_reqs = 0;
   int checked = 0;
   int list_entries = 0;
   int status_seen[4] = '{0, 0, 0, 0};
   int errors = 0;

   stable_priority_batch_sorter_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_entry_id(req_entry_id), .req_level_code(req_level_code),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_kind(rsp_result_kind), .rsp_status_code(rsp_status_code),
      .rsp_out_id(rsp_out_id), .rsp_out_level(rsp_out_level), .rsp_last(rsp_last),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   function automatic void push_status(status_type st, logic [ENTRY_ID_W-1:0] id,
                                       logic [LEVEL_W-1:0] lvl, logic last);
      due_results.push_back('{KIND_STATUS, st, id, lvl, last});
      status_seen[st]++;
   endfunction

   // held entries out stably by level, then the store is empty
   function automatic void emit_batch();
      int emitted = 0;
      for (int l = 0; l < 3; l++) begin
         for (int i = 0; i < batch_fill; i++) begin
            if (batch_lvls[i] == l) begin
               emitted++;
               due_results.push_back('{KIND_LIST, ST_ACCEPTED, batch_ids[i],
                                       LEVEL_W'(l), emitted == batch_fill});
               list_entries++;
            end
         end
      end
      batch_fill = 0;
   endfunction

   function automatic void sort_step(logic [ENTRY_ID_W-1:0] id, logic [LEVEL_W-1:0] lvl);
      int limit;
      bit dup;
      limit = (batch_reg == 0) ? 1 :
              (batch_reg > SPBS_MAX_ENTRIES) ? SPBS_MAX_ENTRIES : int'(batch_reg);
      if (batch_fill >= limit) begin
         push_status(ST_FULL, id, lvl, batch_fill == 0);
         emit_batch();
         return;
      end
      dup = 0;
      for (int i = 0; i < batch_fill; i++)
         if (batch_ids[i] == id) dup = 1;
      if (dup) begin
         push_status(ST_DUPLICATE, id, lvl, 1'b1);
         return;
      end
      if (lvl == LVL_INVALID) begin
         push_status(ST_INVALID, id, lvl, 1'b1);
         return;
      end
      if (batch_fill < SPBS_MAX_ENTRIES) begin
         batch_ids[batch_fill] = id;
         batch_lvls[batch_fill] = lvl;
         batch_fill++;
      end
      if (batch_fill >= limit) begin
         push_status(ST_ACCEPTED, id, lvl, 1'b0);
         emit_batch();
      end else begin
         push_status(ST_ACCEPTED, id, lvl, 1'b1);
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            sort_step(req_entry_id, req_level_code);
            accepted_reqs++;
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               req_valid <= 1'b1;
               req_entry_id <= req_backlog[0].id;
               req_level_code <= req_backlog[0].lvl;
               void'(req_backlog.pop_front());
               if ($urandom_range(0, 99) < idle_pct) req_gap = $urandom_range(1, 7);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (due_results.size() == 0) begin
               $error("unexpected result: kind %0d id %h", rsp_result_kind, rsp_out_id);
               errors++;
            end else begin
               want = due_results.pop_front();
               if (rsp_result_kind !== want.kind) begin
                  $error("result_kind: expected %0d, actual %0d", want.kind, rsp_result_kind);
                  errors++;
               end
               if (rsp_status_code !== want.status) begin
                  $error("status_code: expected %0d, actual %0d", want.status,
                         rsp_status_code);
                  errors++;
               end
               if (rsp_out_id !== want.id) begin
                  $error("out_id: expected %h, actual %h", want.id, rsp_out_id);
                  errors++;
               end
               if (rsp_out_level !== want.lvl) begin
                  $error("out_level: expected %0d, actual %0d", want.lvl, rsp_out_level);
                  errors++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_last);
                  errors++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!pressure_done && accepted_reqs >= PRESSURE_AT &&
                      req_backlog.size() > 8) begin
            pressure_done = 1;
            hold_left = PRESSURE_CYCLES;
            rsp_ready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 99) < idle_pct) rsp_stall = $urandom_range(1, 7);
         end
      end
   end

   task automatic csr_write(logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= BATCH_SIZE_ADDR;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      batch_reg = data[BATCH_W-1:0];
   endtask

   task automatic drain();
      while (req_backlog.size() > 0 || req_valid || due_results.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic void offer(logic [ENTRY_ID_W-1:0] id, logic [LEVEL_W-1:0] lvl);
      req_backlog.push_back('{id, lvl});
   endfunction

   task automatic random_phase(int bsize, int n, int pct);
      logic [ENTRY_ID_W-1:0] base;
      logic [ENTRY_ID_W-1:0] id;
      logic [LEVEL_W-1:0]    lvl;
      csr_write(bsize);
      idle_pct = pct;
      base = ENTRY_ID_W'($urandom);
      for (int k = 0; k < n; k++) begin
         // mostly ids from a narrow pool so duplicates show up
         if ($urandom_range(0, 99) < 65) id = base + ENTRY_ID_W'($urandom_range(0, 15));
         else id = ENTRY_ID_W'($urandom);
         lvl = ($urandom_range(0, 9) == 0) ? LVL_INVALID : LEVEL_W'($urandom_range(0, 2));
         offer(id, lvl);
      end
      drain();
   endtask

   initial begin
      int sizes[10];
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed
      idle_pct = 25;
      csr_write(0);
      offer(16'h0000, LVL_HIGH);
      offer(16'hFFFF, LVL_INVALID);
      drain();
      csr_write(6);
      offer(16'hFFFF, LVL_LOW);
      offer(16'h0001, LVL_MID);
      offer(16'hFFFF, LVL_INVALID);
      offer(16'hFFFF, LVL_HIGH);
      offer(16'h1234, LVL_INVALID);
      offer(16'h8000, LVL_HIGH);
      offer(16'h0002, LVL_LOW);
      offer(16'h7FFF, LVL_MID);
      offer(16'h0003, LVL_HIGH);
      offer(16'hAAAA, LVL_MID);
      offer(16'h5555, LVL_HIGH);
      offer(16'h0F0F, LVL_LOW);
      drain();
      // batch size dropped below the open batch
      csr_write(2);
      offer(16'hAAAA, LVL_HIGH);
      drain();

      // random
      sizes = '{63, 1, 32, 5, 40, 0, 2, 17, 0, 0};
      sizes[8] = $urandom_range(2, 31);
      sizes[9] = $urandom_range(3, 12);
      for (int p = 0; p < 10; p++)
         random_phase(sizes[p], $urandom_range(22, 30),
                      (p == 9) ? 0 : ((p % 3 == 1) ? 0 : 30));

      $display("Sent %0d requests, checked %0d results (%0d ordered list entries).",
               accepted_reqs, checked, list_entries);
      $display("Statuses accepted/duplicate/invalid/full: %0d/%0d/%0d/%0d.",
               status_seen[ST_ACCEPTED], status_seen[ST_DUPLICATE],
               status_seen[ST_INVALID], status_seen[ST_FULL]);
      if (errors == 0 && due_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
